@@ hw/rtl/mmp_pkg.sv @@
// Shared types and constants of the matrix multiply and power block.
// No dependencies; every other file of the block but mmp_ram refers to this package.

package mmp_pkg;

    localparam int DATA_W     = 64;
    localparam int EXP_W      = 31;
    localparam int CFG_W      = 4;
    localparam int NUM_RAMS   = 5;
    localparam int RESULT_MAX = 64;
    localparam int LOAD_POS_W = 6;

    typedef enum logic [1:0] {
        ACT_LOAD_A   = 2'd0,
        ACT_LOAD_B   = 2'd1,
        ACT_MULTIPLY = 2'd2,
        ACT_POWER    = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_idx_t;

    // Operand sources. The first five are also the RAM instance numbers.
    typedef enum logic [2:0] {
        SRC_A     = 3'd0,
        SRC_B     = 3'd1,
        SRC_W0    = 3'd2,
        SRC_W1    = 3'd3,
        SRC_W2    = 3'd4,
        SRC_IDENT = 3'd5
    } src_t;

    typedef enum logic [1:0] {
        MUL_LL = 2'd0,
        MUL_LH = 2'd1,
        MUL_HL = 2'd2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_START  = 2'd1,
        ACC_ADD_LO = 2'd2,
        ACC_ADD_HI = 2'd3
    } acc_op_t;

    typedef struct packed {
        act_t               action;
        logic [DATA_W-1:0]  element_value;
        logic [EXP_W-1:0]   exponent;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]  result_value;
        logic               last_of_run;
    } out_item_t;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic [NUM_RAMS-1:0] wr_en;
        logic                wr_from_acc;
        src_t                src_x;
        src_t                src_y;
        logic                ident_bit;
        logic                cap;
        logic                mul_en;
        mul_sel_t            mul_sel;
        acc_op_t             acc_op;
        logic                out_load;
        logic                out_from_acc;
        logic                out_last;
    } ctrl_cmd_t;

endpackage

@@ hw/rtl/mmp_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.

module mmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ hw/rtl/mmp_datapath.sv @@
// Datapath: element stores, operand registers, shared 32x32 multiplier,
// accumulator and result register. Depends on mmp_pkg and mmp_ram.

module mmp_datapath #(
    parameter int MAX_DIM = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mmp_pkg::ctrl_cmd_t               cmd,
    input  logic [mmp_pkg::DATA_W-1:0]       element_value,
    input  logic [2*$clog2(MAX_DIM)-1:0]     rd_addr_x,
    input  logic [2*$clog2(MAX_DIM)-1:0]     rd_addr_y,
    input  logic [2*$clog2(MAX_DIM)-1:0]     wr_addr,
    output mmp_pkg::out_item_t               result,
    output logic                             result_strobe
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int DW    = mmp_pkg::DATA_W;
    localparam int HW    = DW / 2;

    logic [DW-1:0] rd_a [mmp_pkg::NUM_RAMS];
    logic [DW-1:0] rd_b [mmp_pkg::NUM_RAMS];
    logic [DW-1:0] wr_data;
    logic [DW-1:0] x_word;
    logic [DW-1:0] y_word;
    logic [HW-1:0] mul_a;
    logic [HW-1:0] mul_b;
    logic [DW-1:0] prod_next;
    logic [DW-1:0] acc_next;

    logic [DW-1:0]       op_x_reg;
    logic [DW-1:0]       op_y_reg;
    logic [DW-1:0]       prod_reg;
    logic [DW-1:0]       acc_reg;
    mmp_pkg::out_item_t  result_reg;
    logic                strobe_reg;

    assign wr_data = cmd.wr_from_acc ? acc_reg : element_value;

    for (genvar g = 0; g < mmp_pkg::NUM_RAMS; g++)
    begin : g_ram
        mmp_ram #(
            .WIDTH (DW),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk       (clk),
            .we        (cmd.wr_en[g]),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .rd_addr_a (rd_addr_x),
            .rd_addr_b (rd_addr_y),
            .rd_data_a (rd_a[g]),
            .rd_data_b (rd_b[g])
        );
    end

    always_comb
    begin
        unique case (cmd.src_x)
            mmp_pkg::SRC_A:  x_word = rd_a[0];
            mmp_pkg::SRC_B:  x_word = rd_a[1];
            mmp_pkg::SRC_W0: x_word = rd_a[2];
            mmp_pkg::SRC_W1: x_word = rd_a[3];
            mmp_pkg::SRC_W2: x_word = rd_a[4];
            default:         x_word = '0;
        endcase
    end

    // The identity matrix has no store; its elements come from the controller.
    always_comb
    begin
        unique case (cmd.src_y)
            mmp_pkg::SRC_A:     y_word = rd_b[0];
            mmp_pkg::SRC_B:     y_word = rd_b[1];
            mmp_pkg::SRC_W0:    y_word = rd_b[2];
            mmp_pkg::SRC_W1:    y_word = rd_b[3];
            mmp_pkg::SRC_W2:    y_word = rd_b[4];
            mmp_pkg::SRC_IDENT: y_word = {{(DW-1){1'b0}}, cmd.ident_bit};
            default:            y_word = '0;
        endcase
    end

    // The low 64 bits of a product need three of the four 32x32 partial products.
    always_comb
    begin
        unique case (cmd.mul_sel)
            mmp_pkg::MUL_LL:
            begin
                mul_a = op_x_reg[HW-1:0];
                mul_b = op_y_reg[HW-1:0];
            end
            mmp_pkg::MUL_LH:
            begin
                mul_a = op_x_reg[HW-1:0];
                mul_b = op_y_reg[DW-1:HW];
            end
            mmp_pkg::MUL_HL:
            begin
                mul_a = op_x_reg[DW-1:HW];
                mul_b = op_y_reg[HW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        unique case (cmd.acc_op)
            mmp_pkg::ACC_HOLD:   acc_next = acc_reg;
            mmp_pkg::ACC_START:  acc_next = prod_reg;
            mmp_pkg::ACC_ADD_LO: acc_next = acc_reg + prod_reg;
            mmp_pkg::ACC_ADD_HI: acc_next = acc_reg + {prod_reg[HW-1:0], {HW{1'b0}}};
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            op_x_reg <= x_word;
            op_y_reg <= y_word;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            result_reg.result_value <= cmd.out_from_acc ? acc_reg : y_word;
            result_reg.last_of_run  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.out_load;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

@@ hw/rtl/mmp_ctrl.sv @@
// Controller: configuration registers, load position tracking, and the
// state machine that sequences multiply, power and result output. Uses mmp_pkg.

module mmp_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mmp_pkg::act_t                     action,
    input  logic [mmp_pkg::EXP_W-1:0]         exponent,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [mmp_pkg::CFG_W-1:0]         cfg_data,
    output mmp_pkg::ctrl_cmd_t                cmd,
    output logic [2*$clog2(MAX_DIM)-1:0]      rd_addr_x,
    output logic [2*$clog2(MAX_DIM)-1:0]      rd_addr_y,
    output logic [2*$clog2(MAX_DIM)-1:0]      wr_addr
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int TW = (2 * DW > 7) ? 2 * DW : 7;
    localparam int PW = mmp_pkg::LOAD_POS_W;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_PSTEP = 11'b000_0000_0010,
        S_RD    = 11'b000_0000_0100,
        S_CAP   = 11'b000_0000_1000,
        S_M0    = 11'b000_0001_0000,
        S_M1    = 11'b000_0010_0000,
        S_M2    = 11'b000_0100_0000,
        S_M3    = 11'b000_1000_0000,
        S_EL    = 11'b001_0000_0000,
        S_ERD   = 11'b010_0000_0000,
        S_EOUT  = 11'b100_0000_0000
    } state_t;

    function automatic logic [DW-1:0] dim_of(input logic [mmp_pkg::CFG_W-1:0] v);
        logic [mmp_pkg::CFG_W:0] v_ext;
        v_ext = {1'b0, v};
        if (v == '0)
        begin
            return DW'(1);
        end
        else if (v_ext > (mmp_pkg::CFG_W + 1)'(MAX_DIM))
        begin
            return DW'(MAX_DIM);
        end
        return DW'(v_ext);
    endfunction

    function automatic logic is_last(input logic [IW-1:0] idx, input logic [DW-1:0] dim);
        return (DW'(idx) + DW'(1)) == dim;
    endfunction

    state_t                      state_reg, state_next;
    logic [mmp_pkg::CFG_W-1:0]   rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [PW-1:0]               pos_reg, pos_next;
    logic [PW-1:0]               lda_row_reg, lda_row_next, ldb_row_reg, ldb_row_next;
    logic [IW-1:0]               lda_col_reg, lda_col_next, ldb_col_reg, ldb_col_next;
    logic [IW-1:0]               i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic                        is_power_reg, is_power_next;
    logic                        square_reg, square_next;
    logic                        odd_done_reg, odd_done_next;
    logic [mmp_pkg::EXP_W-1:0]   expo_reg, expo_next;
    mmp_pkg::src_t               base_reg, base_next;
    mmp_pkg::src_t               acc_src_reg, acc_src_next;
    mmp_pkg::src_t               dest_reg, dest_next;

    logic [DW-1:0]  n_dim, m_dim, p_dim, walk_m, walk_p;
    logic [TW-1:0]  prod_total, total;
    logic           out_last, i_last, j_last, k_last, ij_last;
    logic           accept, cfg_we, cfg_hit;
    mmp_pkg::src_t  free_src;

    logic [TW-1:0]  size_sel, e_pos, e_inc;
    logic           e_zero, wrap;
    logic [PW-1:0]  a_row_b, b_row_b, a_row_n, b_row_n;
    logic [IW-1:0]  a_col_b, b_col_b, a_col_n, b_col_n;
    logic           a_col_end, b_col_end;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_we && (cfg_index == mmp_pkg::CFG_ROWS_A ||
                                  cfg_index == mmp_pkg::CFG_INNER_DIM ||
                                  cfg_index == mmp_pkg::CFG_COLS_B);

    assign n_dim  = dim_of(rows_a_reg);
    assign m_dim  = dim_of(inner_dim_reg);
    assign p_dim  = dim_of(cols_b_reg);
    assign walk_m = is_power_reg ? n_dim : m_dim;
    assign walk_p = is_power_reg ? n_dim : p_dim;

    assign prod_total = TW'(n_dim) * TW'(walk_p);
    assign total      = (prod_total > TW'(mmp_pkg::RESULT_MAX)) ?
                        TW'(mmp_pkg::RESULT_MAX) : prod_total;
    assign out_last   = (TW'(cnt_reg) + TW'(1)) == total;

    assign i_last  = is_last(i_reg, n_dim);
    assign j_last  = is_last(j_reg, walk_p);
    assign k_last  = is_last(k_reg, walk_m);
    assign ij_last = i_last && j_last;

    // The result of a product goes to the work store that holds neither operand.
    always_comb
    begin
        if (base_reg != mmp_pkg::SRC_W0 && acc_src_reg != mmp_pkg::SRC_W0)
        begin
            free_src = mmp_pkg::SRC_W0;
        end
        else if (base_reg != mmp_pkg::SRC_W1 && acc_src_reg != mmp_pkg::SRC_W1)
        begin
            free_src = mmp_pkg::SRC_W1;
        end
        else
        begin
            free_src = mmp_pkg::SRC_W2;
        end
    end

    // The load position is kept as a linear count and also as row and column
    // for each store's shape, so that no division is needed for the address.
    always_comb
    begin
        size_sel  = (action == mmp_pkg::ACT_LOAD_A) ? TW'(n_dim) * TW'(m_dim)
                                                    : TW'(m_dim) * TW'(p_dim);
        e_zero    = TW'(pos_reg) >= size_sel;
        e_pos     = e_zero ? '0 : TW'(pos_reg);
        e_inc     = e_pos + TW'(1);
        wrap      = (e_inc >= size_sel) || (e_inc == TW'(1 << PW));
        a_row_b   = e_zero ? '0 : lda_row_reg;
        a_col_b   = e_zero ? '0 : lda_col_reg;
        b_row_b   = e_zero ? '0 : ldb_row_reg;
        b_col_b   = e_zero ? '0 : ldb_col_reg;
        a_col_end = (DW'(a_col_b) + DW'(1)) == m_dim;
        b_col_end = (DW'(b_col_b) + DW'(1)) == p_dim;
        a_row_n   = a_col_end ? a_row_b + PW'(1) : a_row_b;
        a_col_n   = a_col_end ? '0 : a_col_b + IW'(1);
        b_row_n   = b_col_end ? b_row_b + PW'(1) : b_row_b;
        b_col_n   = b_col_end ? '0 : b_col_b + IW'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        lda_row_next  = lda_row_reg;
        lda_col_next  = lda_col_reg;
        ldb_row_next  = ldb_row_reg;
        ldb_col_next  = ldb_col_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        is_power_next = is_power_reg;
        square_next   = square_reg;
        odd_done_next = odd_done_reg;
        expo_next     = expo_reg;
        base_next     = base_reg;
        acc_src_next  = acc_src_reg;
        dest_next     = dest_reg;

        cmd.wr_en        = '0;
        cmd.wr_from_acc  = 1'b1;
        cmd.src_x        = is_power_reg ? base_reg : mmp_pkg::SRC_A;
        cmd.src_y        = mmp_pkg::SRC_B;
        cmd.ident_bit    = (k_reg == j_reg);
        cmd.cap          = 1'b0;
        cmd.mul_en       = 1'b0;
        cmd.mul_sel      = mmp_pkg::MUL_LL;
        cmd.acc_op       = mmp_pkg::ACC_HOLD;
        cmd.out_load     = 1'b0;
        cmd.out_from_acc = 1'b1;
        cmd.out_last     = out_last;

        if (is_power_reg)
        begin
            cmd.src_y = square_reg ? base_reg : acc_src_reg;
        end

        rd_addr_x = {i_reg, k_reg};
        rd_addr_y = (state_reg == S_ERD) ? {i_reg, j_reg} : {k_reg, j_reg};
        wr_addr   = {i_reg, j_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        mmp_pkg::ACT_LOAD_A, mmp_pkg::ACT_LOAD_B:
                        begin
                            cmd.wr_from_acc = 1'b0;
                            if (action == mmp_pkg::ACT_LOAD_A)
                            begin
                                cmd.wr_en[mmp_pkg::SRC_A] = 1'b1;
                                wr_addr = {a_row_b[IW-1:0], a_col_b};
                            end
                            else
                            begin
                                cmd.wr_en[mmp_pkg::SRC_B] = 1'b1;
                                wr_addr = {b_row_b[IW-1:0], b_col_b};
                            end
                            pos_next     = wrap ? '0 : e_inc[PW-1:0];
                            lda_row_next = wrap ? '0 : a_row_n;
                            lda_col_next = wrap ? '0 : a_col_n;
                            ldb_row_next = wrap ? '0 : b_row_n;
                            ldb_col_next = wrap ? '0 : b_col_n;
                        end
                        mmp_pkg::ACT_MULTIPLY:
                        begin
                            pos_next      = '0;
                            lda_row_next  = '0;
                            lda_col_next  = '0;
                            ldb_row_next  = '0;
                            ldb_col_next  = '0;
                            is_power_next = 1'b0;
                            i_next        = '0;
                            j_next        = '0;
                            k_next        = '0;
                            cnt_next      = '0;
                            state_next    = S_RD;
                        end
                        mmp_pkg::ACT_POWER:
                        begin
                            pos_next      = '0;
                            lda_row_next  = '0;
                            lda_col_next  = '0;
                            ldb_row_next  = '0;
                            ldb_col_next  = '0;
                            is_power_next = 1'b1;
                            expo_next     = exponent;
                            base_next     = mmp_pkg::SRC_A;
                            acc_src_next  = mmp_pkg::SRC_IDENT;
                            odd_done_next = 1'b0;
                            state_next    = S_PSTEP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else if (cfg_hit)
                begin
                    pos_next     = '0;
                    lda_row_next = '0;
                    lda_col_next = '0;
                    ldb_row_next = '0;
                    ldb_col_next = '0;
                end
            end

            // One step of square-and-multiply: accumulate on a set bit, then
            // shift the exponent and square the base while bits remain.
            S_PSTEP:
            begin
                i_next = '0;
                j_next = '0;
                k_next = '0;
                if (expo_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = S_ERD;
                end
                else if (expo_reg[0] && !odd_done_reg)
                begin
                    square_next = 1'b0;
                    dest_next   = free_src;
                    state_next  = S_RD;
                end
                else
                begin
                    expo_next     = expo_reg >> 1;
                    odd_done_next = 1'b0;
                    if ((expo_reg >> 1) != '0)
                    begin
                        square_next = 1'b1;
                        dest_next   = free_src;
                        state_next  = S_RD;
                    end
                end
            end

            S_RD:
            begin
                state_next = S_CAP;
            end

            S_CAP:
            begin
                cmd.cap    = 1'b1;
                state_next = S_M0;
            end

            S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mmp_pkg::MUL_LL;
                state_next  = S_M1;
            end

            S_M1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mmp_pkg::MUL_LH;
                cmd.acc_op  = (k_reg == '0) ? mmp_pkg::ACC_START : mmp_pkg::ACC_ADD_LO;
                state_next  = S_M2;
            end

            S_M2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mmp_pkg::MUL_HL;
                cmd.acc_op  = mmp_pkg::ACC_ADD_HI;
                state_next  = S_M3;
            end

            S_M3:
            begin
                cmd.acc_op = mmp_pkg::ACC_ADD_HI;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = S_EL;
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_RD;
                end
            end

            S_EL:
            begin
                if (j_last)
                begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
                if (!is_power_reg)
                begin
                    cmd.out_load = 1'b1;
                    cnt_next     = cnt_reg + 6'd1;
                    state_next   = out_last ? S_IDLE : S_RD;
                end
                else
                begin
                    cmd.wr_en[dest_reg] = 1'b1;
                    if (ij_last)
                    begin
                        if (square_reg)
                        begin
                            base_next = dest_reg;
                        end
                        else
                        begin
                            acc_src_next  = dest_reg;
                            odd_done_next = 1'b1;
                        end
                        state_next = S_PSTEP;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_ERD:
            begin
                state_next = S_EOUT;
            end

            S_EOUT:
            begin
                cmd.src_y        = acc_src_reg;
                cmd.ident_bit    = (i_reg == j_reg);
                cmd.out_load     = 1'b1;
                cmd.out_from_acc = 1'b0;
                cnt_next         = cnt_reg + 6'd1;
                if (j_last)
                begin
                    j_next = '0;
                    i_next = i_reg + IW'(1);
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
                state_next = out_last ? S_IDLE : S_ERD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mmp_pkg::CFG_W'(2);
            inner_dim_reg <= mmp_pkg::CFG_W'(2);
            cols_b_reg    <= mmp_pkg::CFG_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mmp_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                mmp_pkg::CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                mmp_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            lda_row_reg  <= '0;
            lda_col_reg  <= '0;
            ldb_row_reg  <= '0;
            ldb_col_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            cnt_reg      <= '0;
            is_power_reg <= 1'b0;
            square_reg   <= 1'b0;
            odd_done_reg <= 1'b0;
            expo_reg     <= '0;
            base_reg     <= mmp_pkg::SRC_A;
            acc_src_reg  <= mmp_pkg::SRC_IDENT;
            dest_reg     <= mmp_pkg::SRC_W0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            lda_row_reg  <= lda_row_next;
            lda_col_reg  <= lda_col_next;
            ldb_row_reg  <= ldb_row_next;
            ldb_col_reg  <= ldb_col_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            is_power_reg <= is_power_next;
            square_reg   <= square_next;
            odd_done_reg <= odd_done_next;
            expo_reg     <= expo_next;
            base_reg     <= base_next;
            acc_src_reg  <= acc_src_next;
            dest_reg     <= dest_next;
        end
    end

    a_power_roles_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && is_power_reg) |-> base_reg != acc_src_reg)
        else $error("power base and accumulator share a store");

    a_dest_not_operand: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EL && is_power_reg) |->
            (dest_reg != base_reg && dest_reg != acc_src_reg))
        else $error("product written over one of its operands");

    a_cfg_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> pos_reg == '0)
        else $error("register write did not restart the load position");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> state_reg == S_IDLE)
        else $error("controller still busy after the last result");

endmodule

@@ hw/rtl/matrix_multiply_and_power.sv @@
// Matrix multiply and power unit, top level. Uses mmp_pkg, mmp_ctrl, mmp_datapath.
// Loads may be issued every cycle while the unit is not busy. Each product term passes
// through S_RD, S_CAP and S_M0 to S_M3 on the shared 32x32 multiplier, and a multiply
// loads each result for its strobe in S_EL. A power passes through S_PSTEP for each
// exponent step and takes up to two matrix products per exponent bit, then emits the
// results, each through S_ERD and S_EOUT. Results cannot be stalled. Reset sets all
// dimensions to 2 and the load position to 0.

module matrix_multiply_and_power #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mmp_pkg::in_item_t             request,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [mmp_pkg::CFG_W-1:0]     cfg_data,
    output mmp_pkg::out_item_t            result,
    output logic                          result_strobe
);

    localparam int AW = 2 * $clog2(MAX_DIM);

    mmp_pkg::ctrl_cmd_t cmd;
    logic [AW-1:0]      rd_addr_x;
    logic [AW-1:0]      rd_addr_y;
    logic [AW-1:0]      wr_addr;

    mmp_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (request.action),
        .exponent  (request.exponent),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rd_addr_x (rd_addr_x),
        .rd_addr_y (rd_addr_y),
        .wr_addr   (wr_addr)
    );

    mmp_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (request.element_value),
        .rd_addr_x     (rd_addr_x),
        .rd_addr_y     (rd_addr_y),
        .wr_addr       (wr_addr),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
